FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// clocked on aclk, disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ffpa_pkg.sv
// types and constants for the first-fit pool allocator
// no dependencies
package ffpa_pkg;

    localparam int POOL_BYTES  = 4096;
    localparam int POOL_AW     = 12;
    localparam int HDR_BYTES   = 24;
    localparam int SPLIT_SLACK = 32;
    localparam int SIZE_W      = 13;
    localparam int ID_W        = 32;
    localparam int STATUS_W    = 3;

    typedef struct packed {
        logic [POOL_AW-1:0] size;
        logic [POOL_AW-1:0] nxt;
        logic               last;
        logic               alloc;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC_OK      = 3'd0,
        ST_ALLOC_FAIL    = 3'd1,
        ST_FREED         = 3'd2,
        ST_FREE_OUTSIDE  = 3'd3,
        ST_FREE_NOT_ALLOC = 3'd4
    } status_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [POOL_AW-1:0] HDR_OFS      = POOL_AW'(HDR_BYTES);
    localparam logic [SIZE_W-1:0]  HDR_OFS_WIDE = SIZE_W'(HDR_BYTES);
    localparam logic [POOL_AW-1:0] INIT_SIZE    = POOL_AW'(POOL_BYTES - HDR_BYTES);
    localparam logic [SIZE_W:0]    SPLIT_MARGIN = (SIZE_W + 1)'(2 * HDR_BYTES + SPLIT_SLACK);

endpackage

FILE: rtl/core/ffpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ffpa_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/first_fit_pool_allocator_unit.sv
// first-fit pool allocator: header store walk, split, free-list push
// depends on ffpa_pkg and ffpa_ram
//
// channel   dir   handshake          payload
// s_        in    s_valid/s_ready    s_kind, s_request_size, s_block_address
// m_        out   m_valid/m_ready    m_status, m_payload_offset, m_block_id
// cfg_      in    cfg_wr_en          cfg_wr_data (split enable)
//
// allocate: head read, free-list walk one header at a time, then up to 3 header writes
// free: read, alloc check, header write; all limited by the one header-store read port
// after reset a clearing pass writes all 4096 headers with s_ready low
// one transaction in flight; a result waits in the output register while m_ready is low
module first_fit_pool_allocator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [ffpa_pkg::SIZE_W-1:0]     s_request_size,
    input  logic [ffpa_pkg::SIZE_W-1:0]     s_block_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ffpa_pkg::STATUS_W-1:0]   m_status,
    output logic [ffpa_pkg::POOL_AW-1:0]    m_payload_offset,
    output logic [ffpa_pkg::ID_W-1:0]       m_block_id,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data
);

    import ffpa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WALK, S_FREE_CHK, S_WR_NB, S_WR_PREV, S_WR_RUN, S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [POOL_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [POOL_AW-1:0]  run_reg, run_next;
    logic [POOL_AW-1:0]  prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    hdr_t                prev_hdr_reg, prev_hdr_next;
    hdr_t                run_hdr_reg, run_hdr_next;
    logic [SIZE_W-1:0]   need_reg, need_next;
    logic                split_reg, split_next;
    logic [POOL_AW-1:0]  step_reg, step_next;
    logic [POOL_AW-1:0]  head_reg, head_next;
    logic                empty_reg, empty_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                split_en_reg, split_en_next;
    status_t             res_status_reg, res_status_next;
    logic [POOL_AW-1:0]  res_payload_reg, res_payload_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [POOL_AW-1:0]  m_payload_reg, m_payload_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;

    logic                mem_we;
    logic [POOL_AW-1:0]  mem_waddr;
    hdr_t                mem_wdata;
    logic [POOL_AW-1:0]  mem_raddr;
    logic [HDR_W-1:0]    mem_rdata;
    hdr_t                rd_hdr;

    logic                fit;
    logic                split_ok;
    logic [POOL_AW-1:0]  nb_addr;
    logic [POOL_AW-1:0]  nb_size;
    logic [SIZE_W-1:0]   free_hdr;
    logic                free_outside;
    logic                accept;

    ffpa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (POOL_BYTES)
    ) u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign rd_hdr       = hdr_t'(mem_rdata);
    assign fit          = {1'b0, rd_hdr.size} >= need_reg;
    assign split_ok     = split_en_reg &&
                          ({2'b00, rd_hdr.size} > ({1'b0, need_reg} + SPLIT_MARGIN));
    assign nb_addr      = run_reg + HDR_OFS + need_reg[POOL_AW-1:0];
    assign nb_size      = run_hdr_reg.size - need_reg[POOL_AW-1:0] - HDR_OFS;
    assign free_hdr     = s_block_address - HDR_OFS_WIDE;
    assign free_outside = (s_block_address < HDR_OFS_WIDE) || free_hdr[SIZE_W-1];
    assign accept       = s_valid && s_ready;

    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        run_next         = run_reg;
        prev_next        = prev_reg;
        have_prev_next   = have_prev_reg;
        prev_hdr_next    = prev_hdr_reg;
        run_hdr_next     = run_hdr_reg;
        need_next        = need_reg;
        split_next       = split_reg;
        step_next        = step_reg;
        head_next        = head_reg;
        empty_next       = empty_reg;
        id_next          = id_reg;
        split_en_next    = cfg_wr_en ? cfg_wr_data : split_en_reg;
        res_status_next  = res_status_reg;
        res_payload_next = res_payload_reg;
        res_id_next      = res_id_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_payload_next   = m_payload_reg;
        m_id_next        = m_id_reg;
        mem_we           = 1'b0;
        mem_waddr        = run_reg;
        mem_wdata        = '0;
        mem_raddr        = run_reg;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == '0) begin
                    mem_wdata.size = INIT_SIZE;
                    mem_wdata.last = 1'b1;
                end
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_payload_next = '0;
                    res_id_next      = '0;
                    if (s_kind == KIND_ALLOC) begin
                        need_next      = s_request_size;
                        have_prev_next = 1'b0;
                        step_next      = '0;
                        run_next       = head_reg;
                        mem_raddr      = head_reg;
                        if (s_request_size == '0 || empty_reg) begin
                            res_status_next = ST_ALLOC_FAIL;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_WALK;
                        end
                    end else begin
                        run_next  = free_hdr[POOL_AW-1:0];
                        mem_raddr = free_hdr[POOL_AW-1:0];
                        if (free_outside) begin
                            res_status_next = ST_FREE_OUTSIDE;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_FREE_CHK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (fit) begin
                    run_hdr_next = rd_hdr;
                    split_next   = split_ok;
                    if (split_ok) begin
                        state_next = S_WR_NB;
                    end else if (have_prev_reg) begin
                        state_next = S_WR_PREV;
                    end else begin
                        if (rd_hdr.last) begin
                            empty_next = 1'b1;
                            head_next  = '0;
                        end else begin
                            head_next = rd_hdr.nxt;
                        end
                        state_next = S_WR_RUN;
                    end
                end else if (rd_hdr.last || step_reg == '1) begin
                    res_status_next = ST_ALLOC_FAIL;
                    state_next      = S_RESP;
                end else begin
                    mem_raddr      = rd_hdr.nxt;
                    run_next       = rd_hdr.nxt;
                    prev_next      = run_reg;
                    prev_hdr_next  = rd_hdr;
                    have_prev_next = 1'b1;
                    step_next      = step_reg + 1'b1;
                end
            end
            S_WR_NB: begin
                mem_we          = 1'b1;
                mem_waddr       = nb_addr;
                mem_wdata.size  = nb_size;
                mem_wdata.nxt   = run_hdr_reg.nxt;
                mem_wdata.last  = run_hdr_reg.last;
                mem_wdata.alloc = 1'b0;
                if (have_prev_reg) begin
                    state_next = S_WR_PREV;
                end else begin
                    head_next  = nb_addr;
                    state_next = S_WR_RUN;
                end
            end
            S_WR_PREV: begin
                mem_we          = 1'b1;
                mem_waddr       = prev_reg;
                mem_wdata.size  = prev_hdr_reg.size;
                mem_wdata.alloc = prev_hdr_reg.alloc;
                if (split_reg) begin
                    mem_wdata.nxt  = nb_addr;
                    mem_wdata.last = 1'b0;
                end else begin
                    mem_wdata.nxt  = run_hdr_reg.nxt;
                    mem_wdata.last = run_hdr_reg.last;
                end
                state_next = S_WR_RUN;
            end
            S_WR_RUN: begin
                mem_we          = 1'b1;
                mem_waddr       = run_reg;
                mem_wdata.size  = split_reg ? need_reg[POOL_AW-1:0] : run_hdr_reg.size;
                mem_wdata.alloc = 1'b1;
                res_status_next  = ST_ALLOC_OK;
                res_payload_next = run_reg + HDR_OFS;
                res_id_next      = id_reg;
                id_next          = id_reg + 1'b1;
                state_next       = S_RESP;
            end
            S_FREE_CHK: begin
                if (!rd_hdr.alloc) begin
                    res_status_next = ST_FREE_NOT_ALLOC;
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = run_reg;
                    mem_wdata.size  = rd_hdr.size;
                    mem_wdata.nxt   = empty_reg ? '0 : head_reg;
                    mem_wdata.last  = empty_reg;
                    mem_wdata.alloc = 1'b0;
                    head_next       = run_reg;
                    empty_next      = 1'b0;
                    res_status_next = ST_FREED;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_payload_next = res_payload_reg;
                    m_id_next      = res_id_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            have_prev_reg <= 1'b0;
            split_reg     <= 1'b0;
            step_reg      <= '0;
            head_reg      <= '0;
            empty_reg     <= 1'b0;
            id_reg        <= ID_W'(1);
            split_en_reg  <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            have_prev_reg <= have_prev_next;
            split_reg     <= split_next;
            step_reg      <= step_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            id_reg        <= id_next;
            split_en_reg  <= split_en_next;
            m_valid_reg   <= m_valid_next;
        end
        run_reg         <= run_next;
        prev_reg        <= prev_next;
        prev_hdr_reg    <= prev_hdr_next;
        run_hdr_reg     <= run_hdr_next;
        need_reg        <= need_next;
        res_status_reg  <= res_status_next;
        res_payload_reg <= res_payload_next;
        res_id_reg      <= res_id_next;
        m_status_reg    <= m_status_next;
        m_payload_reg   <= m_payload_next;
        m_id_reg        <= m_id_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_payload_reg;
    assign m_block_id       = m_id_reg;

endmodule

FILE: rtl/core/ffpa_checker.sv
// port-level checks for the first-fit pool allocator, bound to the top level
// depends on ffpa_pkg and assert_macros.svh
`include "assert_macros.svh"

module ffpa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_kind,
    input logic [ffpa_pkg::SIZE_W-1:0]     s_request_size,
    input logic [ffpa_pkg::SIZE_W-1:0]     s_block_address,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [ffpa_pkg::STATUS_W-1:0]   m_status,
    input logic [ffpa_pkg::POOL_AW-1:0]    m_payload_offset,
    input logic [ffpa_pkg::ID_W-1:0]       m_block_id,
    input logic                            cfg_wr_en,
    input logic                            cfg_wr_data
);

    import ffpa_pkg::*;

    logic out_stall;
    logic fail_res;
    logic res_empty;

    assign out_stall = m_valid && !m_ready;
    assign fail_res  = m_valid && (m_status != ST_ALLOC_OK);
    assign res_empty = (m_payload_offset == '0) && (m_block_id == '0);

    // stalled result transaction holds
    `ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_status) && $stable(m_block_id))

    // only successful allocations carry an offset and an id
    `ASSERT_IMP(a_fail_zero, fail_res, res_empty)

    // one request at a time
    `ASSERT_NEXT(a_one_busy, s_valid && s_ready, !s_ready)

    // clearing pass right after reset
    `ASSERT_IMP(a_clear_busy, !$past(aresetn), !s_ready && !m_valid)

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (.*);
